// File: rtl/sine_taylor_approximation_assert.svh
// assertion macros for the sine pipeline
// included by the top level, no other dependencies
`ifndef SINE_TAYLOR_APPROXIMATION_ASSERT_SVH
`define SINE_TAYLOR_APPROXIMATION_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/sta_pkg.sv
// constants, pipeline payload type and pi helpers for the sine pipeline
// no dependencies
package sta_pkg;

    // fixed-point word for the series: unsigned Q2.30
    localparam int QW = 32;
    localparam int QF = 30;

    // pi in Q4.60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // series coefficients 1/6, 1/20, 1/42, 1/72 in Q0.30
    localparam logic [QW-1:0] COEF_3 = 32'd178956971;
    localparam logic [QW-1:0] COEF_5 = 32'd53687091;
    localparam logic [QW-1:0] COEF_7 = 32'd25565282;
    localparam logic [QW-1:0] COEF_9 = 32'd14913081;

    // loose upper bound on the folded angle (pi/2 in Q2.30 plus rounding)
    localparam logic [QW-1:0] X_MAX = 32'd1687000000;
    // largest series magnitude in Q2.30
    localparam logic [QW-1:0] SUM_MAX = 32'd1073745920;

    typedef struct packed {
        logic [QW-1:0] x;
        logic [QW-1:0] x2;
        logic [QW-1:0] acc;
        logic          neg;
    } side_t;

    // pi with frac fraction bits, rounded to nearest
    function automatic logic [63:0] pi_units(input int frac);
        return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

    // pi/2 with frac fraction bits, rounded to nearest
    function automatic logic [63:0] pio2_units(input int frac);
        return (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

endpackage

// File: rtl/sta_divstep.sv
// one registered restoring-division step against pi << SHIFT
// depends on sta_pkg
module sta_divstep #(
    parameter int AW    = 32,
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] rem_a,
    input  logic          sgn_a,
    output logic [AW-1:0] rem_b,
    output logic          sgn_b
);
    import sta_pkg::*;

    localparam logic [63:0]   PI_A64  = pi_units(AW - 8);
    localparam logic [AW-1:0] DIVISOR = AW'(PI_A64 << SHIFT);

    logic          ge;
    logic [AW-1:0] rem_next;
    logic          sgn_next;
    logic [AW-1:0] rem_reg;
    logic          sgn_reg;

    assign ge       = rem_a >= DIVISOR;
    assign rem_next = ge ? (rem_a - DIVISOR) : rem_a;
    // the last step gives the quotient lsb, which flips the output sign
    assign sgn_next = (SHIFT == 0) ? (sgn_a ^ ge) : sgn_a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            sgn_reg <= sgn_next;
        end
    end

    assign rem_b = rem_reg;
    assign sgn_b = sgn_reg;

endmodule

// File: rtl/sta_mulq30.sv
// registered Q2.30 multiply with floor back to Q2.30
// depends on sta_pkg
module sta_mulq30 (
    input  logic                 clk,
    input  logic                 en,
    input  logic [sta_pkg::QW-1:0] a,
    input  logic [sta_pkg::QW-1:0] b,
    output logic [sta_pkg::QW-1:0] p
);
    import sta_pkg::*;

    logic [2*QW-1:0] full;
    logic [QW-1:0]   p_reg;

    assign full = (2*QW)'(a) * (2*QW)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= full[QF+QW-1:QF];
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/sine_taylor_approximation.sv
// sine of a fixed-point angle: input in signed Q8.24 radians, result in signed Q2.30
// top level; uses sta_pkg, sta_divstep, sta_mulq30 and the assertion macro header
//
// usage:
//   angle channel: angle_valid / angle_ready with the angle on angle.
//   sine channel: sine_valid / sine_ready with the result on sine.
//   a transfer happens at a rising edge where valid and ready are both high.
// pipeline: 19 register stages; a result is presented once its angle has passed
//   through all of them and transfers when the output is not stalled.
//   stage 0 takes the magnitude, stages 1-6 divide by pi one quotient bit each,
//   stage 7 folds to [0, pi/2], stages 8-16 are the chain of nine multipliers,
//   stage 17 closes the series sum and stage 18 scales and applies the sign.
// throughput: one angle per clock while the output is not stalled; stages 1-7 each
//   hold one wide compare and subtract and stages 8-16 one 32x32 multiply each.
// reset: all stages go empty, nothing is presented, angle_ready is high.
// stall: when sine_ready is low the result holds; stages behind it keep moving
//   into empty slots, so bubbles close up and angle_ready drops only once every
//   stage is full.
`include "sine_taylor_approximation_assert.svh"

module sine_taylor_approximation #(
    parameter int ANGLE_WIDTH  = 32,
    parameter int RESULT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           angle_valid,
    output logic                           angle_ready,
    input  logic signed [ANGLE_WIDTH-1:0]  angle,
    output logic                           sine_valid,
    input  logic                           sine_ready,
    output logic signed [RESULT_WIDTH-1:0] sine
);
    import sta_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam int RW = RESULT_WIDTH;
    localparam int NS = 19;

    localparam logic [63:0]   PI_A64   = pi_units(AW - 8);
    localparam logic [63:0]   PIO2_A64 = pio2_units(AW - 8);
    localparam logic [AW-1:0] PI_A     = AW'(PI_A64);
    localparam logic [AW-1:0] PIO2_A   = AW'(PIO2_A64);

    logic [NS-1:0]   v_reg;
    logic [NS:0]     rdy;

    logic [AW-1:0]   angle_u;
    logic [AW-1:0]   mag_next;
    logic            lez_next;
    logic [AW-1:0]   mag0_reg;
    logic            neg0_reg;

    logic [AW-1:0]   rem_w [0:6];
    logic            neg_w [0:6];

    logic [AW-1:0]   r_fold;
    logic [QW-1:0]   x_q30;

    side_t           side_reg  [7:17];
    side_t           side_next [7:17];

    logic [QW-1:0]   ma [8:16];
    logic [QW-1:0]   mb [8:16];
    logic [QW-1:0]   prod_w [8:16];

    logic [RW-1:0]   scaled;
    logic [RW-1:0]   sine_next;
    logic [RW-1:0]   sine_reg;

    // ready runs back from the output; a stage moves when it is empty or drains
    assign rdy[NS] = sine_ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= angle_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: magnitude and the "angle <= 0" flag
    assign angle_u  = angle;
    assign mag_next = angle_u[AW-1] ? (~angle_u + AW'(1)) : angle_u;
    assign lez_next = angle_u[AW-1] || (angle_u == '0);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag0_reg <= mag_next;
            neg0_reg <= lez_next;
        end
    end

    // stages 1-6: half-turn count, one quotient bit per stage
    assign rem_w[0] = mag0_reg;
    assign neg_w[0] = neg0_reg;

    for (genvar k = 1; k <= 6; k++)
    begin : g_div
        sta_divstep #(
            .AW    (AW),
            .SHIFT (6 - k)
        ) u_divstep (
            .clk   (clk),
            .en    (rdy[k]),
            .rem_a (rem_w[k-1]),
            .sgn_a (neg_w[k-1]),
            .rem_b (rem_w[k]),
            .sgn_b (neg_w[k])
        );
    end

    // stage 7: fold to [0, pi/2] and move to Q2.30
    assign r_fold = (rem_w[6] >= PIO2_A) ? (PI_A - rem_w[6]) : rem_w[6];

    if (AW <= 38)
    begin : g_xup
        assign x_q30 = QW'(r_fold) << (38 - AW);
    end
    else
    begin : g_xdn
        assign x_q30 = QW'(r_fold >> (AW - 38));
    end

    // multiplier operands: x^2, then term * x^2 and term * coefficient in turn
    always_comb
    begin
        ma[8]  = side_reg[7].x;   mb[8]  = side_reg[7].x;
        ma[9]  = side_reg[8].x;   mb[9]  = prod_w[8];
        ma[10] = prod_w[9];       mb[10] = COEF_3;
        ma[11] = prod_w[10];      mb[11] = side_reg[10].x2;
        ma[12] = prod_w[11];      mb[12] = COEF_5;
        ma[13] = prod_w[12];      mb[13] = side_reg[12].x2;
        ma[14] = prod_w[13];      mb[14] = COEF_7;
        ma[15] = prod_w[14];      mb[15] = side_reg[14].x2;
        ma[16] = prod_w[15];      mb[16] = COEF_9;
    end

    for (genvar k = 8; k <= 16; k++)
    begin : g_mul
        sta_mulq30 u_mul (
            .clk (clk),
            .en  (rdy[k]),
            .a   (ma[k]),
            .b   (mb[k]),
            .p   (prod_w[k])
        );
    end

    // side payload; the series sum builds up as each term appears
    always_comb
    begin
        side_next[7].x   = x_q30;
        side_next[7].x2  = '0;
        side_next[7].acc = '0;
        side_next[7].neg = neg_w[6];
        for (int k = 8; k <= 17; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[9].x2   = prod_w[8];
        side_next[11].acc = side_reg[10].x - prod_w[10];
        side_next[13].acc = side_reg[12].acc + prod_w[12];
        side_next[15].acc = side_reg[14].acc - prod_w[14];
        side_next[17].acc = side_reg[16].acc + prod_w[16];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 7; k <= 17; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // stage 18: scale to the result format and apply the sign
    if (RW >= QW)
    begin : g_sup
        assign scaled = RW'(side_reg[17].acc) << (RW - QW);
    end
    else
    begin : g_sdn
        assign scaled = RW'(side_reg[17].acc >> (QW - RW));
    end

    assign sine_next = side_reg[17].neg ? (~scaled + RW'(1)) : scaled;

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            sine_reg <= sine_next;
        end
    end

    assign angle_ready = rdy[0];
    assign sine_valid  = v_reg[NS-1];
    assign sine        = sine_reg;

    `STA_ASSERT_NOW(a_rem_below_pi, clk, rst_n, v_reg[6], rem_w[6] < PI_A, "remainder not below pi")
    `STA_ASSERT_NOW(a_fold_range, clk, rst_n, v_reg[7], side_reg[7].x <= X_MAX, "folded angle above pi/2")
    `STA_ASSERT_NOW(a_sum_range, clk, rst_n, v_reg[17], side_reg[17].acc <= SUM_MAX, "series sum out of range")
    `STA_ASSERT_NEXT(a_no_drop, clk, rst_n, v_reg[6] && rdy[6], v_reg[7], "item lost between stages")
    `STA_ASSERT_NOW(a_empty_takes, clk, rst_n, !sine_valid, angle_ready, "empty pipeline refuses input")

endmodule
